// ===== rtl/cmv_pkg.sv =====
// Shared types and constants for the chunk manifest validator.
`timescale 1ns / 1ps

package cmv_pkg;

    // Size limits
    localparam logic [31:0] CHUNK_BYTES_MAX = 32'h0100_0000;          // 2^24
    localparam logic [63:0] PART_BYTES_MAX  = 64'h0000_4000_0000_0000; // 2^46

    // Configuration register reset values
    localparam logic [31:0] MAX_CHUNKS_RST = 32'd65536;
    localparam logic [31:0] MAX_PARTS_RST  = 32'd4096;

    // Register index decoded from paddr[2]
    localparam logic REG_MAX_CHUNKS = 1'b0;
    localparam logic REG_MAX_PARTS  = 1'b1;

    // Decoupling queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Result codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INCONS      = 3'd1,
        ST_MANY_CHUNKS = 3'd2,
        ST_OVERSIZE    = 3'd3,
        ST_MANY_PARTS  = 3'd4,
        ST_OVERFLOW    = 3'd5,
        ST_NO_MANIFEST = 3'd6
    } status_t;

    // Classified word handed from front to back.
    // On a header, ident_lo carries the chunk count and end_sum the total size.
    typedef struct packed {
        logic        is_chunk;
        status_t     hdr_status;
        logic [31:0] ident_lo;
        logic        ident_hi_zero;
        logic [63:0] start;
        logic [63:0] end_sum;
        logic        carry;
        logic        size_zero;
        logic        size_over;
        logic        digest_zero;
    } qentry_t;

endpackage

// ===== rtl/cmv_front.sv =====
// Front end: configuration registers, input acceptance and state-free checks.
`timescale 1ns / 1ps

module cmv_front
    import cmv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_sel,
    input  logic [31:0] cfg_wdata,
    output logic [31:0] cfg_rdata,
    // input word
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [63:0] ident,
    input  logic [63:0] total_size,
    input  logic [31:0] chunk_total,
    input  logic [63:0] exchange_ident,
    input  logic [63:0] producer_ident,
    input  logic [63:0] chunk_start,
    input  logic [31:0] chunk_size,
    input  logic [63:0] digest_w0,
    input  logic [63:0] digest_w1,
    input  logic [63:0] digest_w2,
    input  logic [63:0] digest_w3,
    // queue side
    input  logic        q_full,
    output logic        q_push,
    output qentry_t     q_data
);

    logic [31:0] max_chunks_reg;
    logic [31:0] max_parts_reg;
    logic [64:0] sum;
    status_t     hdr_status;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chunks_reg <= MAX_CHUNKS_RST;
            max_parts_reg  <= MAX_PARTS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_sel == REG_MAX_CHUNKS)
                max_chunks_reg <= cfg_wdata;
            else
                max_parts_reg <= cfg_wdata;
        end
    end

    assign cfg_rdata = (cfg_sel == REG_MAX_CHUNKS) ? max_chunks_reg : max_parts_reg;

    // Header checks, first failing check wins
    always_comb
    begin
        if (chunk_total == 32'd0)
            hdr_status = ST_INCONS;
        else if (chunk_total > max_chunks_reg)
            hdr_status = ST_MANY_CHUNKS;
        else if (total_size == 64'd0)
            hdr_status = ST_INCONS;
        else if (total_size > PART_BYTES_MAX)
            hdr_status = ST_OVERSIZE;
        else if (ident >= {32'd0, max_parts_reg})
            hdr_status = ST_MANY_PARTS;
        else if (exchange_ident == 64'd0)
            hdr_status = ST_INCONS;
        else if (producer_ident == 64'd0)
            hdr_status = ST_INCONS;
        else
            hdr_status = ST_OK;
    end

    // Chunk end offset with carry out
    assign sum = {1'b0, chunk_start} + {33'd0, chunk_size};

    // Build queue word
    always_comb
    begin
        q_data.is_chunk      = opcode;
        q_data.hdr_status    = hdr_status;
        q_data.ident_lo      = opcode ? ident[31:0] : chunk_total;
        q_data.ident_hi_zero = (ident[63:32] == 32'd0);
        q_data.start         = chunk_start;
        q_data.end_sum       = opcode ? sum[63:0] : total_size;
        q_data.carry         = sum[64];
        q_data.size_zero     = (chunk_size == 32'd0);
        q_data.size_over     = (chunk_size > CHUNK_BYTES_MAX);
        q_data.digest_zero   = ((digest_w0 | digest_w1 | digest_w2 | digest_w3) == 64'd0);
    end

    assign in_stall = q_full;
    assign q_push   = in_valid & ~q_full;

endmodule

// ===== rtl/cmv_queue.sv =====
// Short FIFO of classified words between front and back.
`timescale 1ns / 1ps

module cmv_queue
    import cmv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  qentry_t push_data,
    input  logic    pop,
    output logic    full,
    output logic    empty,
    output qentry_t head
);

    qentry_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/cmv_back.sv =====
// Back end: manifest state, state-dependent checks and the result register.
`timescale 1ns / 1ps

module cmv_back
    import cmv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // queue side
    input  logic        q_empty,
    input  qentry_t     q_head,
    output logic        q_pop,
    // result word
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        final_res
);

    logic        open_reg,     open_next;
    logic [31:0] index_reg,    index_next;
    logic [63:0] expect_reg,   expect_next;
    logic [31:0] decl_cnt_reg, decl_cnt_next;
    logic [63:0] decl_tot_reg, decl_tot_next;
    logic        valid_reg;
    status_t     status_reg,   status_next;
    logic        final_reg,    final_next;
    logic [31:0] index_inc;
    status_t     chunk_status;

    // Take a word when the result register is free or being drained
    assign q_pop = ~q_empty & (~valid_reg | ~out_stall);

    assign index_inc = index_reg + 32'd1;

    // Chunk checks, first failing check wins
    always_comb
    begin
        if (!q_head.ident_hi_zero || q_head.ident_lo != index_reg)
            chunk_status = ST_INCONS;
        else if (q_head.size_zero)
            chunk_status = ST_INCONS;
        else if (q_head.size_over)
            chunk_status = ST_OVERSIZE;
        else if (q_head.start != expect_reg)
            chunk_status = ST_INCONS;
        else if (q_head.digest_zero)
            chunk_status = ST_INCONS;
        else if (q_head.carry)
            chunk_status = ST_OVERFLOW;
        else
            chunk_status = ST_OK;
    end

    // Manifest state update and verdict
    always_comb
    begin
        open_next     = open_reg;
        index_next    = index_reg;
        expect_next   = expect_reg;
        decl_cnt_next = decl_cnt_reg;
        decl_tot_next = decl_tot_reg;
        status_next   = ST_OK;
        final_next    = 1'b0;
        if (!q_head.is_chunk)
        begin
            status_next = q_head.hdr_status;
            index_next  = 32'd0;
            expect_next = 64'd0;
            if (q_head.hdr_status == ST_OK)
            begin
                open_next     = 1'b1;
                decl_cnt_next = q_head.ident_lo;
                decl_tot_next = q_head.end_sum;
            end
            else
            begin
                open_next  = 1'b0;
                final_next = 1'b1;
            end
        end
        else if (!open_reg)
        begin
            status_next = ST_NO_MANIFEST;
        end
        else if (chunk_status != ST_OK)
        begin
            status_next = chunk_status;
            open_next   = 1'b0;
            final_next  = 1'b1;
        end
        else
        begin
            expect_next = q_head.end_sum;
            index_next  = index_inc;
            // last declared chunk closes the manifest
            if (index_inc == decl_cnt_reg)
            begin
                if (q_head.end_sum != decl_tot_reg)
                    status_next = ST_INCONS;
                open_next  = 1'b0;
                final_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg     <= 1'b0;
            index_reg    <= 32'd0;
            expect_reg   <= 64'd0;
            decl_cnt_reg <= 32'd0;
            decl_tot_reg <= 64'd0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                open_reg     <= open_next;
                index_reg    <= index_next;
                expect_reg   <= expect_next;
                decl_cnt_reg <= decl_cnt_next;
                decl_tot_reg <= decl_tot_next;
                valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            status_reg <= status_next;
            final_reg  <= final_next;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign final_res = final_reg;

endmodule

// ===== rtl/chunk_manifest_validator_unit.sv =====
// Top level of the chunk manifest validator.
`timescale 1ns / 1ps

// Checks a partition manifest word by word: a header word opens a manifest, chunk
// words follow, and every input word yields exactly one result word (status and
// final flag). One word is accepted per clock while the queue is not full; the
// accepted word is written into the queue and then loaded into the result
// register, which drives the output. The input stalls only while the two-entry
// queue is full, which takes a stalled output. The front classifies each word
// against the configuration with no manifest state involved, a two-entry queue
// decouples it from the back, and the back applies the index, offset and total
// checks against the running manifest state.
// The chunk limit sits at byte address 0 and the partition limit at 4; write them
// only while the block is idle.

module chunk_manifest_validator_unit
    import cmv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [63:0] ident,
    input  logic [63:0] total_size,
    input  logic [31:0] chunk_total,
    input  logic [63:0] exchange_ident,
    input  logic [63:0] producer_ident,
    input  logic [63:0] chunk_start,
    input  logic [31:0] chunk_size,
    input  logic [63:0] digest_w0,
    input  logic [63:0] digest_w1,
    input  logic [63:0] digest_w2,
    input  logic [63:0] digest_w3,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic        final_res
);

    logic    cfg_we;
    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    qentry_t q_wdata;
    qentry_t q_head;

    // Register write strobe
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    cmv_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_sel        (paddr[2]),
        .cfg_wdata      (pwdata),
        .cfg_rdata      (prdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .ident          (ident),
        .total_size     (total_size),
        .chunk_total    (chunk_total),
        .exchange_ident (exchange_ident),
        .producer_ident (producer_ident),
        .chunk_start    (chunk_start),
        .chunk_size     (chunk_size),
        .digest_w0      (digest_w0),
        .digest_w1      (digest_w1),
        .digest_w2      (digest_w2),
        .digest_w3      (digest_w3),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_wdata)
    );

    cmv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    cmv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .final_res (final_res)
    );

endmodule
